// ----- rtl/assert_macros.svh -----
// assertion helpers; every use sits inside a module with clk and rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold on every clock edge out of reset
`define CHK_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define CHK_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pathsimp_pkg.sv -----
package pathsimp_pkg;

  // path characters with a meaning
  localparam logic [7:0] SLASH = 8'h2F;
  localparam logic [7:0] DOT   = 8'h2E;

  // segment start stack
  localparam int unsigned STACK_SIZE = 32;
  localparam int unsigned STK_AW     = $clog2(STACK_SIZE);
  localparam int unsigned DEPTH_W    = $clog2(STACK_SIZE + 1);

  // one character of the simplified path
  typedef struct packed {
    logic [7:0] char_byte;
    logic       last;
    logic       ovf;
  } out_item_t;

endpackage

// ----- rtl/pathsimp_ram.sv -----
module pathsimp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/pathsimp_out.sv -----
module pathsimp_out
  import pathsimp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t item,
  output logic      free,
  output logic      out_valid,
  input  logic      out_ready,
  output logic [7:0] out_byte,
  output logic      out_last,
  output logic      out_overflow
);

  logic      valid_r;
  logic      valid_nxt;
  out_item_t item_r;

  // stage is free when empty or being drained this cycle
  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (valid_r && out_ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      item_r <= item;
    end
  end

  assign out_valid    = valid_r;
  assign out_byte     = item_r.char_byte;
  assign out_last     = item_r.last;
  assign out_overflow = item_r.ovf;

endmodule

// ----- rtl/path_simplifier_top.sv -----
// Streaming path simplifier. Path characters come in one item per cycle
// on the in_ channel while in_ready is high, with in_path_last on the
// final one; the simplified path leaves on the out_ channel one character
// per item, out_last on its final character and out_overflow set on every
// item when characters were dropped because the text buffer (MAX_LEN
// bytes) was full. A character that opens a kept segment writes the
// slash, then each held-back leading dot, then the character itself, since
// each buffered byte is one write on the text memory port. A '/' that ends
// a '..' segment waits in S_POP for the stack read. The final item may pass
// through S_END to close its segment and S_POP to pop the stack, then the
// result streams from the text memory read port one character per cycle
// while the output stage is free, after a read start; no new item is taken
// until the last character is loaded into the output register.
`include "assert_macros.svh"

module path_simplifier_top
  import pathsimp_pkg::*;
#(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_path_byte,
  input  logic       in_path_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_overflow
);

  localparam int unsigned AW   = $clog2(MAX_LEN);
  localparam int unsigned WP_W = $clog2(MAX_LEN + 1);

  // leading dot count codes; ordinary means already in the buffer
  localparam logic [1:0] DOTS_NONE = 2'd0;
  localparam logic [1:0] DOTS_TWO  = 2'd2;
  localparam logic [1:0] DOTS_ORD  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DOTS,
    S_END,
    S_POP,
    S_EMIT_RD,
    S_EMIT
  } state_t;

  state_t             state_r, state_nxt;
  logic [WP_W-1:0]    wp_r, wp_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic [1:0]         dots_r, dots_nxt;
  logic               ovf_r, ovf_nxt;
  logic [7:0]         char_r, char_nxt;
  logic [1:0]         dcnt_r, dcnt_nxt;
  logic               last_r, last_nxt;
  logic [AW-1:0]      rd_idx_r, rd_idx_nxt;

  logic               txt_we;
  logic [AW-1:0]      txt_waddr;
  logic [7:0]         txt_wdata;
  logic [AW-1:0]      txt_raddr;
  logic [7:0]         txt_rdata;

  logic               stk_we;
  logic [STK_AW-1:0]  stk_waddr;
  logic [AW-1:0]      stk_wdata;
  logic [STK_AW-1:0]  stk_raddr;
  logic [AW-1:0]      stk_rdata;

  logic               put_req;
  logic [7:0]         put_data;
  logic               out_load;
  out_item_t          out_item;
  logic               out_free;
  logic               accept;
  logic               buf_room;
  logic [DEPTH_W-1:0] depth_dec;
  logic [WP_W-1:0]    idx_inc;
  logic               streaming;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign buf_room  = wp_r < WP_W'(MAX_LEN);
  assign depth_dec = depth_r - DEPTH_W'(1);
  assign idx_inc   = WP_W'(rd_idx_r) + WP_W'(1);
  assign streaming = (state_r == S_EMIT) || (state_r == S_EMIT_RD);

  // text buffer and segment start stack
  pathsimp_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text (
    .clk   (clk),
    .we    (txt_we),
    .waddr (txt_waddr),
    .wdata (txt_wdata),
    .raddr (txt_raddr),
    .rdata (txt_rdata)
  );

  pathsimp_ram #(.WIDTH(AW), .DEPTH(STACK_SIZE)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // output register stage
  pathsimp_out u_out (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (out_load),
    .item         (out_item),
    .free         (out_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_overflow (out_overflow)
  );

  // sequencer: parse, push and pop segments, then stream the buffer
  always_comb begin
    state_nxt  = state_r;
    wp_nxt     = wp_r;
    depth_nxt  = depth_r;
    dots_nxt   = dots_r;
    ovf_nxt    = ovf_r;
    char_nxt   = char_r;
    dcnt_nxt   = dcnt_r;
    last_nxt   = last_r;
    rd_idx_nxt = rd_idx_r;
    put_req    = 1'b0;
    put_data   = SLASH;
    stk_we     = 1'b0;
    stk_waddr  = depth_r[STK_AW-1:0];
    stk_wdata  = wp_r[AW-1:0];
    stk_raddr  = depth_dec[STK_AW-1:0];
    txt_raddr  = rd_idx_r;
    out_load   = 1'b0;
    out_item   = '{char_byte: SLASH, last: 1'b1, ovf: ovf_r};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          last_nxt = in_path_last;
          if (in_path_byte == SLASH) begin
            // segment ends; '..' drops the last kept segment
            if (dots_r == DOTS_TWO && depth_r != '0) begin
              depth_nxt = depth_dec;
              state_nxt = S_POP;
            end else begin
              dots_nxt = DOTS_NONE;
              if (in_path_last) begin
                state_nxt = S_EMIT_RD;
              end
            end
          end else if (dots_r == DOTS_ORD) begin
            put_req  = 1'b1;
            put_data = in_path_byte;
            if (in_path_last) begin
              state_nxt = S_END;
            end
          end else if (in_path_byte == DOT && dots_r < DOTS_TWO) begin
            dots_nxt = dots_r + 2'd1;
            if (in_path_last) begin
              state_nxt = S_END;
            end
          end else begin
            // segment is kept: push its start if buffer and stack have room, and write the slash
            if (buf_room && depth_r < DEPTH_W'(STACK_SIZE)) begin
              stk_we    = 1'b1;
              depth_nxt = depth_r + DEPTH_W'(1);
            end
            put_req   = 1'b1;
            put_data  = SLASH;
            char_nxt  = in_path_byte;
            dcnt_nxt  = dots_r;
            state_nxt = S_DOTS;
          end
        end
      end

      S_DOTS: begin
        // held dots, then the character that opened the segment
        put_req = 1'b1;
        if (dcnt_r != 2'd0) begin
          put_data = DOT;
          dcnt_nxt = dcnt_r - 2'd1;
        end else begin
          put_data  = char_r;
          dots_nxt  = DOTS_ORD;
          state_nxt = last_r ? S_END : S_IDLE;
        end
      end

      S_END: begin
        if (dots_r == DOTS_TWO && depth_r != '0) begin
          depth_nxt = depth_dec;
          state_nxt = S_POP;
        end else begin
          dots_nxt  = DOTS_NONE;
          state_nxt = S_EMIT_RD;
        end
      end

      S_POP: begin
        // stack read issued last cycle
        wp_nxt    = WP_W'(stk_rdata);
        dots_nxt  = DOTS_NONE;
        state_nxt = last_r ? S_EMIT_RD : S_IDLE;
      end

      S_EMIT_RD: begin
        if (wp_r == '0) begin
          // nothing kept: lone slash
          if (out_free) begin
            out_load  = 1'b1;
            wp_nxt    = '0;
            depth_nxt = '0;
            dots_nxt  = DOTS_NONE;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end
        end else begin
          txt_raddr  = '0;
          rd_idx_nxt = '0;
          state_nxt  = S_EMIT;
        end
      end

      S_EMIT: begin
        // read data belongs to rd_idx_r; re-read it while stalled
        if (out_free) begin
          out_load   = 1'b1;
          out_item   = '{char_byte: txt_rdata, last: (idx_inc == wp_r), ovf: ovf_r};
          txt_raddr  = idx_inc[AW-1:0];
          rd_idx_nxt = idx_inc[AW-1:0];
          if (idx_inc == wp_r) begin
            wp_nxt    = '0;
            depth_nxt = '0;
            dots_nxt  = DOTS_NONE;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // buffer write, or drop and flag when full
    txt_we    = 1'b0;
    txt_waddr = wp_r[AW-1:0];
    txt_wdata = put_data;
    if (put_req) begin
      if (buf_room) begin
        txt_we = 1'b1;
        wp_nxt = wp_r + WP_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r    <= '0;
      depth_r <= '0;
      dots_r  <= DOTS_NONE;
      ovf_r   <= 1'b0;
      last_r  <= 1'b0;
      dcnt_r  <= 2'd0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      depth_r <= depth_nxt;
      dots_r  <= dots_nxt;
      ovf_r   <= ovf_nxt;
      last_r  <= last_nxt;
      dcnt_r  <= dcnt_nxt;
    end
    char_r   <= char_nxt;
    rd_idx_r <= rd_idx_nxt;
  end

  `CHK_ALWAYS(a_wp_bound, wp_r <= WP_W'(MAX_LEN), "write pointer past buffer end")
  `CHK_ALWAYS(a_depth_bound, depth_r <= DEPTH_W'(STACK_SIZE), "stack depth past stack size")
  `CHK_IMPLY(a_no_write_emit, streaming, !txt_we && !stk_we, "memory written while streaming")
  `CHK_IMPLY(a_load_free, out_load, out_free, "item loaded into busy output stage")

endmodule

// ----- dv/path_simplifier_top_tb.sv -----
`timescale 1ns / 1ps

module path_simplifier_top_tb;
  import pathsimp_pkg::*;

  localparam int unsigned MAX_LEN     = 64;
  localparam int unsigned N_DIRECTED  = 10;
  localparam int unsigned RAND_BYTES  = 500;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned DRAIN_WAIT  = 16;

  logic       clk;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_ready;
  logic [7:0] in_path_byte = 8'h00;
  logic       in_path_last = 1'b0;
  logic       out_valid;
  logic       out_ready    = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_overflow;

  path_simplifier_top #(
    .MAX_LEN(MAX_LEN)
  ) uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_path_byte(in_path_byte),
    .in_path_last(in_path_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_last    (out_last),
    .out_overflow(out_overflow)
  );

  // directed paths; '#' stands for a zero byte, an empty want means predicted
  string dir_path [N_DIRECTED] = '{
    "/", ".", "..", "a/..", "...", "x//y/", "a/b/..", "#\377", ".a", "..b/"
  };
  string dir_want [N_DIRECTED] = '{
    "/", "/", "/", "/", "/...", "/x/y", "/a", "/#\377", "", ""
  };

  // simplified characters still to come out, oldest first
  out_item_t expected_chars[$];

  // predictor state
  logic [7:0] kept_text [MAX_LEN];
  logic [6:0] text_len;
  logic [5:0] seg_start [STACK_SIZE];
  logic [5:0] seg_depth;
  logic [6:0] seg_len;
  logic [1:0] held_dots;
  logic       bytes_dropped;

  logic [7:0]  path_q[$];
  int unsigned burst_left     = 0;
  int unsigned mismatch_count = 0;
  int unsigned chars_checked  = 0;
  int unsigned bytes_sent     = 0;
  int unsigned paths_sent     = 0;
  int unsigned overflow_paths = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // hard limit on run length
  initial begin
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------
  // path simplification predictor
  // ---------------------------------------------------------------------

  function automatic void clear_path();
    text_len      = '0;
    seg_depth     = '0;
    seg_len       = '0;
    held_dots     = '0;
    bytes_dropped = 1'b0;
  endfunction

  function automatic void keep_char(input logic [7:0] c);
    if (text_len < MAX_LEN) begin
      kept_text[text_len] = c;
      text_len++;
    end else begin
      bytes_dropped = 1'b1;
    end
  endfunction

  // a segment turns out to be kept: record its start, write slash, held dots and the character
  function automatic void start_segment(input logic [7:0] c);
    if (text_len < MAX_LEN && seg_depth < STACK_SIZE) begin
      seg_start[seg_depth] = text_len[5:0];
      seg_depth++;
    end
    keep_char(SLASH);
    for (int i = 0; i < held_dots; i++) keep_char(DOT);
    keep_char(c);
    held_dots = 2'd3;
  endfunction

  // a '..' segment pops the last kept one
  function automatic void close_segment();
    if (held_dots == 2'd2 && seg_depth > 0) begin
      seg_depth--;
      text_len = {1'b0, seg_start[seg_depth]};
    end
    held_dots = '0;
    seg_len   = '0;
  endfunction

  function automatic void simplify_char(input logic [7:0] b, input logic last,
                                        input bit record);
    if (b == SLASH) begin
      close_segment();
    end else begin
      if (held_dots == 2'd3) keep_char(b);
      else if (b == DOT && held_dots < 2'd2) held_dots++;
      else start_segment(b);
      if (seg_len < 7'd127) seg_len++;
    end
    if (last) begin
      close_segment();
      if (bytes_dropped) overflow_paths++;
      if (record) begin
        if (text_len == 0) begin
          expected_chars.push_back(out_item_t'{char_byte: SLASH, last: 1'b1,
                                               ovf: bytes_dropped});
        end else begin
          for (int i = 0; i < text_len; i++)
            expected_chars.push_back(out_item_t'{char_byte: kept_text[i],
                                                 last: (i == text_len - 1),
                                                 ovf: bytes_dropped});
        end
      end
      clear_path();
    end
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  function automatic logic [7:0] char_at(input string s, input int i);
    char_at = (s[i] == "#") ? 8'h00 : s[i];
  endfunction

  // mostly letters, some dots, some arbitrary bytes other than slash
  function automatic logic [7:0] name_char();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      name_char = 8'($urandom_range(97, 122));
    end else if (r == 7) begin
      name_char = DOT;
    end else begin
      do name_char = 8'($urandom_range(0, 255)); while (name_char == SLASH);
    end
  endfunction

  function automatic void build_random_path();
    int unsigned kind;
    int unsigned nseg;
    int unsigned len;
    path_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      // noise: arbitrary bytes with slashes now and then
      len = $urandom_range(1, 40);
      repeat (len)
        path_q.push_back(($urandom_range(0, 3) == 0) ? SLASH : 8'($urandom_range(0, 255)));
    end else begin
      // long names overflow the buffer, many one-char segments stress the stack
      if ($urandom_range(0, 4) != 0) path_q.push_back(SLASH);
      if (kind < 20) nseg = $urandom_range(3, 6);
      else if (kind < 28) nseg = $urandom_range(30, 36);
      else nseg = $urandom_range(1, 8);
      for (int s = 0; s < nseg; s++) begin
        if (s != 0) path_q.push_back(SLASH);
        case ($urandom_range(0, 9))
          0: ;
          1: path_q.push_back(DOT);
          2: repeat (2) path_q.push_back(DOT);
          3: repeat (3) path_q.push_back(DOT);
          default: begin
            if (kind < 20) len = $urandom_range(8, 30);
            else if (kind < 28) len = 1;
            else len = $urandom_range(1, 6);
            repeat (len) path_q.push_back(name_char());
          end
        endcase
      end
      if ($urandom_range(0, 2) == 0) path_q.push_back(SLASH);
      if (path_q.size() == 0) path_q.push_back(SLASH);
    end
  endfunction

  // offer one path byte in bursts with random gaps, predict on acceptance
  task automatic push_char(input logic [7:0] b, input logic last, input bit record);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_path_byte <= b;
    in_path_last <= last;
    do @(posedge clk); while (!in_ready);
    simplify_char(b, last, record);
    bytes_sent++;
  endtask

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------

  initial begin : stimulus
    int unsigned rand_bytes;
    string       want;
    int          n;
    rand_bytes = 0;
    clear_path();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed paths
    for (int r = 0; r < N_DIRECTED; r++) begin
      want = dir_want[r];
      n    = dir_path[r].len();
      for (int i = 0; i < n; i++)
        push_char(char_at(dir_path[r], i), i == n - 1, want.len() == 0);
      for (int i = 0; i < want.len(); i++)
        expected_chars.push_back(out_item_t'{char_byte: char_at(want, i),
                                             last: (i == want.len() - 1),
                                             ovf: 1'b0});
      paths_sent++;
    end

    // random paths
    while (rand_bytes < RAND_BYTES) begin
      build_random_path();
      foreach (path_q[i]) push_char(path_q[i], i == path_q.size() - 1, 1'b1);
      rand_bytes += path_q.size();
      paths_sent++;
    end
    in_valid <= 1'b0;

    // drain
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("ran %0d paths of %0d bytes in total, %0d with dropped bytes",
             paths_sent, bytes_sent, overflow_paths);
    $display("checked %0d output characters, %0d mismatches",
             chars_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // ---------------------------------------------------------------------
  // receiver: rotating stall patterns plus one long hold-off
  // ---------------------------------------------------------------------

  initial begin : receiver
    int unsigned rx_cycle;
    bit          held_off;
    rx_cycle = 0;
    held_off = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!held_off && chars_checked > 150 && out_valid) begin
        // long hold-off so the block backs up and stops taking bytes
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case ((rx_cycle / 48) % 4)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= (rx_cycle % 4 == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
        rx_cycle++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // output check
  // ---------------------------------------------------------------------

  always @(posedge clk) begin : check_output
    out_item_t want_char;
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected output char %02h last %0b ovf %0b",
                 $time, out_byte, out_last, out_overflow);
        mismatch_count++;
      end else begin
        want_char = expected_chars.pop_front();
        chars_checked++;
        if (out_byte !== want_char.char_byte || out_last !== want_char.last ||
            out_overflow !== want_char.ovf) begin
          $display("%0t: mismatch expected char %02h last %0b ovf %0b, got %02h %0b %0b",
                   $time, want_char.char_byte, want_char.last, want_char.ovf,
                   out_byte, out_last, out_overflow);
          mismatch_count++;
        end
      end
    end
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pathsimp_pkg.sv
rtl/pathsimp_ram.sv
rtl/pathsimp_out.sv
rtl/path_simplifier_top.sv
dv/path_simplifier_top_tb.sv
